/* design/optb_pkg.sv */
// optb_pkg: shared constants, types and codes for the timer bank
// depends on nothing; used by the interfaces and every design module
package optb_pkg;

  // bank size and field widths
  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SLOT_W     = 4;
  localparam int AMT_W      = 32;

  // action codes carried by the request channel
  typedef enum logic [1:0] {
    ACT_ONCE     = 2'd0,
    ACT_PERIODIC = 2'd1,
    ACT_STOP     = 2'd2,
    ACT_TICK     = 2'd3
  } action_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_TICK  = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

  // control from the sequencer to the row of cells
  typedef struct packed {
    logic              shift;
    logic              load;
    logic [SLOT_W-1:0] load_slot;
    logic [AMT_W-1:0]  load_rem;
    logic [AMT_W-1:0]  load_rel;
  } cell_ctl_t;

endpackage

/* design/optb_if.sv */
// optb_req_if and optb_rsp_if: valid/ready channels of the timer bank
// depends on optb_pkg
interface optb_req_if;
  logic                          valid;
  logic                          ready;
  optb_pkg::action_t             action;
  logic [optb_pkg::SLOT_W-1:0]   slot;
  logic [optb_pkg::AMT_W-1:0]    amount_us;

  modport source (output valid, output action, output slot, output amount_us, input ready);
  modport sink   (input valid, input action, input slot, input amount_us, output ready);
endinterface

interface optb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          fired;
  logic [optb_pkg::SLOT_W-1:0]   fired_slot;
  logic                          last;

  modport source (output valid, output fired, output fired_slot, output last, input ready);
  modport sink   (input valid, input fired, input fired_slot, input last, output ready);
endinterface

/* design/optb_cell.sv */
// optb_cell: one timer slot of the rotating row (remaining count and period)
// depends on optb_pkg
module optb_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic                       load,
  input  logic [optb_pkg::AMT_W-1:0] load_rem,
  input  logic [optb_pkg::AMT_W-1:0] load_rel,
  input  logic [optb_pkg::AMT_W-1:0] nb_rem,
  input  logic [optb_pkg::AMT_W-1:0] nb_rel,
  output logic [optb_pkg::AMT_W-1:0] rem,
  output logic [optb_pkg::AMT_W-1:0] rel
);

  // take the neighbour's timer while rotating, else a command write
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      rel <= '0;
    end else if (shift) begin
      rem <= nb_rem;
      rel <= nb_rel;
    end else if (load) begin
      rem <= load_rem;
      rel <= load_rel;
    end
  end

endmodule

/* design/optb_ctrl.sv */
// optb_ctrl: sequencer, head-of-row timer update and result register
// depends on optb_pkg, optb_req_if, optb_rsp_if
module optb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  optb_req_if.sink                   req,
  optb_rsp_if.source                 rsp,
  input  logic [optb_pkg::AMT_W-1:0] head_rem,
  input  logic [optb_pkg::AMT_W-1:0] head_rel,
  output logic [optb_pkg::AMT_W-1:0] wrap_rem,
  output logic [optb_pkg::AMT_W-1:0] wrap_rel,
  output optb_pkg::cell_ctl_t        ctl
);

  localparam logic [optb_pkg::IDX_W-1:0] LAST_IDX =
    optb_pkg::IDX_W'(optb_pkg::NUM_TIMERS - 1);

  optb_pkg::state_t                state;
  optb_pkg::state_t                state_next;
  logic [optb_pkg::IDX_W-1:0]      idx;
  logic [optb_pkg::AMT_W-1:0]      amt;
  logic                            pend_valid;
  logic [optb_pkg::SLOT_W-1:0]     pend_slot;

  logic                            out_free;
  logic                            accept;
  logic                            is_tick;
  logic                            head_run;
  logic                            head_exp;
  logic                            step;
  logic                            push;
  logic                            push_fired;
  logic [optb_pkg::SLOT_W-1:0]     push_slot;
  logic                            push_last;

  // head timer update as it wraps round to the far end
  assign head_run = (head_rem != '0);
  assign head_exp = head_run && (head_rem <= amt);
  assign wrap_rem = head_exp ? head_rel : (head_run ? (head_rem - amt) : head_rem);
  assign wrap_rel = head_rel;

  // handshake helpers
  assign out_free = !rsp.valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign is_tick  = (req.action == optb_pkg::ACT_TICK);
  assign step     = (state == optb_pkg::ST_TICK) && !(head_exp && pend_valid && !out_free);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      optb_pkg::ST_IDLE: begin
        if (accept && is_tick) state_next = optb_pkg::ST_TICK;
      end
      optb_pkg::ST_TICK: begin
        if (step && (idx == LAST_IDX)) state_next = optb_pkg::ST_FLUSH;
      end
      optb_pkg::ST_FLUSH: begin
        if (out_free) state_next = optb_pkg::ST_IDLE;
      end
      default: state_next = optb_pkg::ST_IDLE;
    endcase
  end

  // outputs: ready, cell control and result push
  always_comb begin
    req.ready     = 1'b0;
    ctl.shift     = step;
    ctl.load      = 1'b0;
    ctl.load_slot = req.slot;
    ctl.load_rem  = '0;
    ctl.load_rel  = '0;
    push          = 1'b0;
    push_fired    = 1'b0;
    push_slot     = '0;
    push_last     = 1'b1;
    case (req.action)
      optb_pkg::ACT_ONCE: begin
        ctl.load_rem = req.amount_us;
      end
      optb_pkg::ACT_PERIODIC: begin
        ctl.load_rem = req.amount_us;
        ctl.load_rel = req.amount_us;
      end
      default: begin
        ctl.load_rem = '0;
      end
    endcase
    case (state)
      optb_pkg::ST_IDLE: begin
        req.ready = out_free;
        if (accept && !is_tick) begin
          ctl.load = 1'b1;
          push     = 1'b1;
        end
      end
      optb_pkg::ST_TICK: begin
        if (step && head_exp && pend_valid) begin
          push       = 1'b1;
          push_fired = 1'b1;
          push_slot  = pend_slot;
          push_last  = 1'b0;
        end
      end
      optb_pkg::ST_FLUSH: begin
        if (out_free) begin
          push       = 1'b1;
          push_fired = pend_valid;
          push_slot  = pend_valid ? pend_slot : '0;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= optb_pkg::ST_IDLE;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && is_tick) begin
        pend_valid <= 1'b0;
      end else if (step && head_exp) begin
        pend_valid <= 1'b1;
      end else if ((state == optb_pkg::ST_FLUSH) && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // tick payload: elapsed amount, slot counter, held expiry
  always_ff @(posedge clk) begin
    if (accept && is_tick) begin
      amt <= req.amount_us;
      idx <= '0;
    end else if (step) begin
      idx <= idx + 1'b1;
    end
    if (step && head_exp) pend_slot <= optb_pkg::SLOT_W'(idx);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (push) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp.fired      <= push_fired;
      rsp.fired_slot <= push_slot;
      rsp.last       <= push_last;
    end
  end

endmodule

/* design/oneshot_periodic_timer_bank.sv */
// oneshot_periodic_timer_bank: top level, a rotating row of timer cells and the sequencer
// depends on optb_pkg, optb_if, optb_cell, optb_ctrl
//
//   channel  direction  payload                          transfer when
//   req      in         action, slot, amount_us          req.valid && req.ready
//   rsp      out        fired, fired_slot, last          rsp.valid && rsp.ready
//
// a start or stop command gives its acknowledge in the result register
// a tick passes the transfer, then the rotation, in which the row rotates one slot per cycle
// past the head update unless held by a stall, then the flush of the held expiry
// (or the none result) with last set
// a stalled result holds the rotation when a second expiry needs the result register
// synchronous reset stops every timer at once; no clearing pass is needed
module oneshot_periodic_timer_bank (
  input  logic        clk,
  input  logic        rst,
  optb_req_if.sink    req,
  optb_rsp_if.source  rsp
);

  localparam int N = optb_pkg::NUM_TIMERS;

  optb_pkg::cell_ctl_t        ctl;
  logic [optb_pkg::AMT_W-1:0] rem_q [N];
  logic [optb_pkg::AMT_W-1:0] rel_q [N];
  logic [optb_pkg::AMT_W-1:0] nb_rem [N];
  logic [optb_pkg::AMT_W-1:0] nb_rel [N];
  logic [optb_pkg::AMT_W-1:0] wrap_rem;
  logic [optb_pkg::AMT_W-1:0] wrap_rel;

  // sequencer
  optb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .head_rem (rem_q[0]),
    .head_rel (rel_q[0]),
    .wrap_rem (wrap_rem),
    .wrap_rel (wrap_rel),
    .ctl      (ctl)
  );

  // row of cells, each fed by its upper neighbour, the last by the head update
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic load_here;

    if (i == N - 1) begin : g_tail
      assign nb_rem[i] = wrap_rem;
      assign nb_rel[i] = wrap_rel;
    end else begin : g_mid
      assign nb_rem[i] = rem_q[i+1];
      assign nb_rel[i] = rel_q[i+1];
    end

    assign load_here = ctl.load &&
      ({{(32-optb_pkg::SLOT_W){1'b0}}, ctl.load_slot} == 32'(i));

    optb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ctl.shift),
      .load     (load_here),
      .load_rem (ctl.load_rem),
      .load_rel (ctl.load_rel),
      .nb_rem   (nb_rem[i]),
      .nb_rel   (nb_rel[i]),
      .rem      (rem_q[i]),
      .rel      (rel_q[i])
    );
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for oneshot_periodic_timer_bank, with a queue-fed driver,
// a result monitor and a transaction-level prediction of the timer bank
// depends on optb_pkg, optb_if and the design files
module tb_top;
  import optb_pkg::*;

  localparam int MAX_RSP    = 16;
  localparam int STALL_CAP  = 3000;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_PCT   = 14;

  typedef struct {
    action_t            action;
    logic [SLOT_W-1:0]  slot;
    logic [AMT_W-1:0]   amount;
  } timer_cmd_t;

  typedef struct {
    logic               fired;
    logic [SLOT_W-1:0]  fired_slot;
    logic               last;
  } timer_rsp_t;

  logic clk = 1'b0;
  logic rst;

  optb_req_if req_ch ();
  optb_rsp_if rsp_ch ();

  oneshot_periodic_timer_bank u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  // predicted bank state and the results it owes
  logic [AMT_W-1:0] remain_us [NUM_TIMERS];
  logic [AMT_W-1:0] period_us [NUM_TIMERS];
  timer_rsp_t       due_results [$];
  timer_cmd_t       pending [$];
  timer_cmd_t       next_cmd;

  int  fail_count = 0;
  int  rsp_seen   = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  int  stall_cyc  = 0;
  int  cycle_no   = 0;
  logic quiet;

  // no random idling on either side inside this window
  assign quiet = (cycle_no >= 800) && (cycle_no < 1600);

  // apply one accepted transfer to the predicted bank and queue its results
  function automatic void advance_bank(action_t act, logic [SLOT_W-1:0] sl,
                                       logic [AMT_W-1:0] amt);
    int         n;
    timer_rsp_t r;
    n = 0;
    if (act != ACT_TICK) begin
      if (int'(sl) < NUM_TIMERS) begin
        case (act)
          ACT_ONCE: begin
            remain_us[sl] = amt;
            period_us[sl] = '0;
          end
          ACT_PERIODIC: begin
            remain_us[sl] = amt;
            period_us[sl] = amt;
          end
          default: begin
            remain_us[sl] = '0;
            period_us[sl] = '0;
          end
        endcase
      end
      r.fired = 1'b0;
      r.fired_slot = '0;
      r.last = 1'b1;
      due_results.push_back(r);
      return;
    end
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (remain_us[i] == '0) continue;
      if (remain_us[i] > amt) begin
        remain_us[i] = remain_us[i] - amt;
      end else begin
        // expiry drops the overshoot
        remain_us[i] = period_us[i];
        if (n < MAX_RSP) begin
          r.fired = 1'b1;
          r.fired_slot = 4'(i);
          r.last = 1'b0;
          due_results.push_back(r);
          n++;
        end
      end
    end
    if (n == 0) begin
      r.fired = 1'b0;
      r.fired_slot = '0;
      r.last = 1'b1;
      due_results.push_back(r);
    end else begin
      r = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endfunction

  task automatic queue_cmd(action_t a, logic [SLOT_W-1:0] s, logic [AMT_W-1:0] v);
    timer_cmd_t c;
    c.action = a;
    c.slot = s;
    c.amount = v;
    pending.push_back(c);
  endtask

  task automatic report_miss(input string what);
    fail_count++;
    if (fail_count <= 10) $display("tb_top: mismatch %s", what);
  endtask

  // request driver: hold the payload until the transfer, then maybe idle
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        advance_bank(req_ch.action, req_ch.slot, req_ch.amount_us);
      if (!req_ch.valid || req_ch.ready) begin
        if (pending.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_cmd = pending.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.action    <= next_cmd.action;
          req_ch.slot      <= next_cmd.slot;
          req_ch.amount_us <= next_cmd.amount;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    timer_rsp_t exp_r;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_seen <= rsp_seen + 1;
        if (due_results.size() == 0) begin
          report_miss($sformatf("unexpected result fired=%0b slot=%0d last=%0b",
                                rsp_ch.fired, rsp_ch.fired_slot, rsp_ch.last));
        end else begin
          exp_r = due_results.pop_front();
          if (rsp_ch.fired !== exp_r.fired || rsp_ch.fired_slot !== exp_r.fired_slot ||
              rsp_ch.last !== exp_r.last)
            report_miss($sformatf({"exp fired=%0b slot=%0d last=%0b",
                                   " got fired=%0b slot=%0d last=%0b"},
                                  exp_r.fired, exp_r.fired_slot, exp_r.last,
                                  rsp_ch.fired, rsp_ch.fired_slot, rsp_ch.last));
        end
      end
      // one long hold-off so the bank fills and stalls its input
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && rsp_seen == 60) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cyc <= 0;
    end else if (stall_cyc >= STALL_CAP) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      stall_cyc <= stall_cyc + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    action_t act;
    int      pick;
    int      sub;
    logic [AMT_W-1:0] amt;

    rst = 1'b1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      remain_us[i] = '0;
      period_us[i] = '0;
    end

    // directed part
    queue_cmd(ACT_TICK, 4'd0, 32'd5);              // tick with nothing running
    queue_cmd(ACT_TICK, 4'd9, 32'd0);              // zero elapsed
    queue_cmd(ACT_ONCE, 4'd0, 32'd1);
    queue_cmd(ACT_PERIODIC, 4'd15, 32'hFFFF_FFFF);
    queue_cmd(ACT_ONCE, 4'd3, 32'd0);              // zero amount leaves it stopped
    queue_cmd(ACT_PERIODIC, 4'd4, 32'd0);
    queue_cmd(ACT_TICK, 4'd15, 32'd0);             // zero elapsed with timers running
    queue_cmd(ACT_TICK, 4'd0, 32'd1);              // one-shot fires exactly
    queue_cmd(ACT_PERIODIC, 4'd5, 32'd10);
    queue_cmd(ACT_PERIODIC, 4'd5, 32'd3);          // restart while running
    queue_cmd(ACT_ONCE, 4'd10, 32'd7);
    queue_cmd(ACT_TICK, 4'd0, 32'd3);
    queue_cmd(ACT_TICK, 4'd0, 32'd5);              // overshoot dropped on slot 5
    queue_cmd(ACT_STOP, 4'd5, 32'hFFFF_FFFF);
    queue_cmd(ACT_STOP, 4'd11, 32'd0);             // stop an idle slot
    queue_cmd(ACT_TICK, 4'd0, 32'hFFFF_FFFF);      // max elapsed fires slot 15
    queue_cmd(ACT_TICK, 4'd0, 32'hFFFF_FFFE);
    queue_cmd(ACT_ONCE, 4'd7, 32'hAAAA_5555);
    queue_cmd(ACT_PERIODIC, 4'd8, 32'h5555_AAAA);
    queue_cmd(ACT_TICK, 4'd6, 32'h5555_AAAA);
    queue_cmd(ACT_STOP, 4'd15, 32'd0);

    // random part, with a full-bank burst now and then
    for (int k = 0; k < 300; k++) begin
      if (k % 100 == 40) begin
        for (int s = 0; s < NUM_TIMERS; s++) begin
          act = ($urandom_range(0, 1) != 0) ? ACT_PERIODIC : ACT_ONCE;
          queue_cmd(act, 4'(s), 32'($urandom_range(1, 4)));
        end
        queue_cmd(ACT_TICK, 4'($urandom_range(0, 15)), 32'd4);
      end
      pick = $urandom_range(0, 99);
      sub = $urandom_range(0, 9);
      if (pick < 35) begin
        act = ($urandom_range(0, 1) != 0) ? ACT_PERIODIC : ACT_ONCE;
        case (sub)
          0:       amt = '0;
          7:       amt = $urandom;
          8:       amt = 32'hFFFF_FFFF - 32'($urandom_range(0, 20));
          9:       amt = 32'($urandom_range(41, 2000));
          default: amt = 32'($urandom_range(1, 40));
        endcase
        queue_cmd(act, 4'($urandom_range(0, 15)), amt);
      end else if (pick < 45) begin
        queue_cmd(ACT_STOP, 4'($urandom_range(0, 15)), $urandom);
      end else begin
        case (sub)
          0, 1:    amt = '0;
          7:       amt = $urandom;
          8:       amt = 32'hFFFF_FFFF;
          9:       amt = 32'($urandom_range(26, 500));
          default: amt = 32'($urandom_range(1, 25));
        endcase
        queue_cmd(ACT_TICK, 4'($urandom_range(0, 15)), amt);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // drain: everything sent, every result back, then a short settle
    while (pending.size() != 0 || req_ch.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
